>>> hdl/pixel_format_converter_defines.svh
// assertion helpers for the pixel format converter
`ifndef PIXEL_FORMAT_CONVERTER_DEFINES_SVH
`define PIXEL_FORMAT_CONVERTER_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define PFC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define PFC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> hdl/pfc_pkg.sv
package pfc_pkg;

	localparam int MAX_CHANNEL_BITS = 8;
	localparam int NUM_CH = 4;
	localparam int PIXEL_W = 32;
	localparam int PROD_W = 2 * MAX_CHANNEL_BITS;
	localparam int WIDTH_W = $clog2(MAX_CHANNEL_BITS + 1);
	localparam int DIV_STEPS = 2;
	localparam int DIV_STAGES = (MAX_CHANNEL_BITS + DIV_STEPS - 1) / DIV_STEPS;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W = 2;

	localparam logic [15:0] SRC_WIDTHS_RST = 16'h8765;
	localparam logic [19:0] SRC_POSITIONS_RST = 20'h58000;
	localparam logic [15:0] DST_WIDTHS_RST = 16'h8765;
	localparam logic [19:0] DST_POSITIONS_RST = 20'h58000;

	typedef logic [PIXEL_W-1:0] pixel_t;
	typedef logic [MAX_CHANNEL_BITS-1:0] chan_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [WIDTH_W-1:0] cwidth_t;
	typedef logic [4:0] cpos_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_WIDTHS = 2'd0,
		CFG_SRC_POSITIONS = 2'd1,
		CFG_DST_WIDTHS = 2'd2,
		CFG_DST_POSITIONS = 2'd3
	} cfg_reg_e;

	// channel 0 red, 1 green, 2 blue, 3 alpha; oversized widths saturate
	function automatic cwidth_t chan_width(input logic [15:0] widths, input int ch);
		logic [3:0] nib;
		cwidth_t w;
		nib = widths[12-4*ch +: 4];
		if (int'(nib) > MAX_CHANNEL_BITS)
			w = cwidth_t'(MAX_CHANNEL_BITS);
		else
			w = cwidth_t'(nib);
		return w;
	endfunction

	function automatic cpos_t chan_pos(input logic [19:0] positions, input int ch);
		return positions[15-5*ch +: 5];
	endfunction

	function automatic chan_t width_max(input cwidth_t w);
		chan_t m;
		for (int b = 0; b < MAX_CHANNEL_BITS; b++)
			m[b] = (b < int'(w));
		return m;
	endfunction

endpackage

>>> hdl/pixel_format_converter.sv
// Pixel format converter: repacks one 32-bit RGB(A) pixel per clock from a
// programmable source layout into a programmable destination layout.
// Input: drive src_pixel and raise start; busy is always low, so a new pixel
// is taken on every clock edge with start high.
// Output: done pulses for one cycle with dst_pixel; the receiver must take it
// then. Results leave in the order the pixels came in.
// Throughput is one pixel per clock.
// The pipeline is extract, multiply by the destination maximum, a divider by
// the source maximum that retires two quotient bits per stage, and repack.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Registers: 0 source widths, 1 source positions,
// 2 destination widths, 3 destination positions. Write them only while no
// pixel is in flight.
// Reset: arst_n clears the pipeline valid bits and loads the default layout
// (widths 8, 7, 6 and 5 for red, green, blue and alpha; red at bit 11,
// green, blue and alpha at bit 0).
module pixel_format_converter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  pfc_pkg::pixel_t    src_pixel,
	output logic               done,
	output pfc_pkg::pixel_t    dst_pixel,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  pfc_pkg::cfg_idx_t  cfg_index,
	input  pfc_pkg::cfg_data_t cfg_data
);
	import pfc_pkg::*;
	`include "pixel_format_converter_defines.svh"

	logic [15:0] src_widths_q;
	logic [19:0] src_positions_q;
	logic [15:0] dst_widths_q;
	logic [19:0] dst_positions_q;

	chan_t smax [NUM_CH];
	chan_t dmax [NUM_CH];
	chan_t divisor [NUM_CH];

	logic  vld_s1;
	chan_t val_s1 [NUM_CH];
	logic  vld_s2;
	prod_t prod_s2 [NUM_CH];

	// entry k of these arrays is pipeline stage 3 + k
	logic  div_vld_s3 [DIV_STAGES];
	prod_t div_rem_s3 [DIV_STAGES][NUM_CH];
	chan_t div_quo_s3 [DIV_STAGES][NUM_CH];

	logic  rem_in_vld [DIV_STAGES];
	prod_t rem_in [DIV_STAGES][NUM_CH];
	chan_t quo_in [DIV_STAGES][NUM_CH];
	prod_t rem_nx [DIV_STAGES][NUM_CH];
	chan_t quo_nx [DIV_STAGES][NUM_CH];

	pixel_t packed_pix;
	logic   res_vld_q;
	pixel_t res_pixel_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign done = res_vld_q;
	assign dst_pixel = res_pixel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_widths_q <= SRC_WIDTHS_RST;
			src_positions_q <= SRC_POSITIONS_RST;
			dst_widths_q <= DST_WIDTHS_RST;
			dst_positions_q <= DST_POSITIONS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_e'(cfg_index))
				CFG_SRC_WIDTHS: src_widths_q <= cfg_data[15:0];
				CFG_SRC_POSITIONS: src_positions_q <= cfg_data;
				CFG_DST_WIDTHS: dst_widths_q <= cfg_data[15:0];
				CFG_DST_POSITIONS: dst_positions_q <= cfg_data;
			endcase
		end
	end

	// a zero source width gives a zero product, so dividing by one yields zero
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			smax[ch] = width_max(chan_width(src_widths_q, ch));
			dmax[ch] = width_max(chan_width(dst_widths_q, ch));
			divisor[ch] = (smax[ch] == '0) ? chan_t'(1) : smax[ch];
		end
	end

	// stage 1: field extraction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < NUM_CH; ch++)
			val_s1[ch] <= chan_t'(src_pixel >> chan_pos(src_positions_q, ch)) & smax[ch];
	end

	// stage 2: scale by the destination maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < NUM_CH; ch++)
			prod_s2[ch] <= prod_t'(val_s1[ch]) * prod_t'(dmax[ch]);
	end

	// divider stages: restoring division, quotient msb first
	always_comb begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (k == 0) begin
				rem_in_vld[k] = vld_s2;
				for (int ch = 0; ch < NUM_CH; ch++) begin
					rem_in[k][ch] = prod_s2[ch];
					quo_in[k][ch] = '0;
				end
			end else begin
				rem_in_vld[k] = div_vld_s3[k-1];
				for (int ch = 0; ch < NUM_CH; ch++) begin
					rem_in[k][ch] = div_rem_s3[k-1][ch];
					quo_in[k][ch] = div_quo_s3[k-1][ch];
				end
			end
		end
	end

	always_comb begin
		prod_t r;
		chan_t q;
		prod_t sub;
		for (int k = 0; k < DIV_STAGES; k++) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				r = rem_in[k][ch];
				q = quo_in[k][ch];
				for (int j = 0; j < DIV_STEPS; j++) begin
					if (k * DIV_STEPS + j < MAX_CHANNEL_BITS) begin
						sub = prod_t'(divisor[ch]) << (MAX_CHANNEL_BITS - 1 - (k * DIV_STEPS + j));
						if (r >= sub) begin
							r = r - sub;
							q[MAX_CHANNEL_BITS - 1 - (k * DIV_STEPS + j)] = 1'b1;
						end
					end
				end
				rem_nx[k][ch] = r;
				quo_nx[k][ch] = q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++)
				div_vld_s3[k] <= 1'b0;
		end else begin
			for (int k = 0; k < DIV_STAGES; k++)
				div_vld_s3[k] <= rem_in_vld[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				div_rem_s3[k][ch] <= rem_nx[k][ch];
				div_quo_s3[k][ch] <= quo_nx[k][ch];
			end
		end
	end

	// repack; a destination without alpha has dmax zero there, so alpha adds nothing
	always_comb begin
		packed_pix = '0;
		for (int ch = 0; ch < NUM_CH; ch++)
			packed_pix = packed_pix
				| (pixel_t'(div_quo_s3[DIV_STAGES-1][ch]) << chan_pos(dst_positions_q, ch));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_vld_q <= 1'b0;
		else
			res_vld_q <= div_vld_s3[DIV_STAGES-1];
	end

	always_ff @(posedge clk) begin
		res_pixel_q <= packed_pix;
	end

	`PFC_ASSERT(a_done_follows_divider, res_vld_q == $past(div_vld_s3[DIV_STAGES-1]), "done out of step with the divider pipeline")

	for (genvar g = 0; g < NUM_CH; g++) begin : g_chk
		`PFC_ASSERT_IMP(a_rem_below_divisor, div_vld_s3[DIV_STAGES-1], div_rem_s3[DIV_STAGES-1][g] < prod_t'(divisor[g]), "divider remainder not below divisor")
		`PFC_ASSERT_IMP(a_quo_within_dmax, div_vld_s3[DIV_STAGES-1], div_quo_s3[DIV_STAGES-1][g] <= dmax[g], "scaled channel above destination maximum")
		`PFC_ASSERT_IMP(a_zero_src_width, vld_s2 && (smax[g] == '0), prod_s2[g] == '0, "channel without source bits gave a nonzero product")
	end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import pfc_pkg::*;

	localparam int CH_ALPHA = 3;
	localparam int PIPE_LATENCY = 3 + DIV_STAGES;
	localparam int RANDOM_PIXELS = 1900;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	pixel_t    src_pixel;
	logic      done;
	pixel_t    dst_pixel;
	logic      cfg_valid;
	logic      cfg_ready;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_data;

	// layout registers as the block should hold them
	logic [15:0] src_widths_q;
	logic [19:0] src_pos_q;
	logic [15:0] dst_widths_q;
	logic [19:0] dst_pos_q;

	pixel_t expected_pixels[$];
	int     fail_count;

	pixel_format_converter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.src_pixel (src_pixel),
		.done      (done),
		.dst_pixel (dst_pixel),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("pixel_format_converter test failed");
		$finish;
	end

	function automatic int clamp_width(input logic [3:0] nib);
		return (int'(nib) > MAX_CHANNEL_BITS) ? MAX_CHANNEL_BITS : int'(nib);
	endfunction

	// rescale every channel by dst_max / src_max and repack at the destination positions
	function automatic pixel_t convert_pixel(input pixel_t pix);
		pixel_t          out_word;
		longint unsigned src_max;
		longint unsigned dst_max;
		longint unsigned chan_val;
		longint unsigned scaled;
		int              src_shift;
		int              dst_shift;
		out_word = '0;
		for (int ch = 0; ch < 4; ch++) begin
			src_max = (64'd1 << clamp_width(src_widths_q[12-4*ch +: 4])) - 64'd1;
			dst_max = (64'd1 << clamp_width(dst_widths_q[12-4*ch +: 4])) - 64'd1;
			src_shift = int'(src_pos_q[15-5*ch +: 5]);
			dst_shift = int'(dst_pos_q[15-5*ch +: 5]);
			chan_val = (64'(pix) >> src_shift) & src_max;
			if (ch == CH_ALPHA && dst_max == 0)
				continue;
			scaled = (src_max == 0) ? 64'd0 : chan_val * dst_max / src_max;
			out_word |= pixel_t'(scaled << dst_shift);
		end
		return out_word;
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic cfg_data_t rand_widths();
		cfg_data_t   data;
		int unsigned r;
		data = cfg_data_t'($urandom);
		for (int ch = 0; ch < 4; ch++) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				data[12-4*ch +: 4] = 4'd0;
			else if (r == 1)
				data[12-4*ch +: 4] = 4'($urandom_range(9, 15));
			else
				data[12-4*ch +: 4] = 4'($urandom_range(1, 8));
		end
		return data;
	endfunction

	function automatic pixel_t rand_pixel();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return pixel_t'($urandom);
	endfunction

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && done) begin
			if (expected_pixels.size() == 0) begin
				$error("dst_pixel: expected none, actual %h", dst_pixel);
				fail_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (dst_pixel !== want) begin
					$error("dst_pixel: expected %h, actual %h", want, dst_pixel);
					fail_count++;
				end
			end
		end
	end

	task automatic send_pixel(input pixel_t pix);
		@(negedge clk);
		start <= 1'b1;
		src_pixel <= pix;
		do @(posedge clk); while (busy);
		expected_pixels.push_back(convert_pixel(pix));
	endtask

	// holds start low for the gap given by the argument
	task automatic pause_start(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_e idx, input cfg_data_t data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SRC_WIDTHS: src_widths_q = data[15:0];
			CFG_SRC_POSITIONS: src_pos_q = data;
			CFG_DST_WIDTHS: dst_widths_q = data[15:0];
			CFG_DST_POSITIONS: dst_pos_q = data;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		repeat (pick_gap()) @(negedge clk);
	endtask

	task automatic load_layout(input cfg_data_t sw, input cfg_data_t sp,
			input cfg_data_t dw, input cfg_data_t dp);
		write_reg(CFG_SRC_WIDTHS, sw);
		write_reg(CFG_SRC_POSITIONS, sp);
		write_reg(CFG_DST_WIDTHS, dw);
		write_reg(CFG_DST_POSITIONS, dp);
	endtask

	task automatic send_probe_set();
		send_pixel('0);
		send_pixel('1);
		send_pixel(pixel_t'($urandom));
		drain();
	endtask

	task automatic test_reset_layout();
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h00FF_0000);
		send_pixel(32'h0000_FF00);
		send_pixel(32'h0000_00FF);
		send_pixel(32'hAAAA_AAAA);
		send_pixel(32'h5555_5555);
		drain();
	endtask

	task automatic test_special_layouts();
		// 565 source without alpha into 8888
		load_layout(20'({4'd5, 4'd6, 4'd5, 4'd0}), 20'({5'd11, 5'd5, 5'd0, 5'd0}),
			20'({4'd8, 4'd8, 4'd8, 4'd8}), 20'({5'd24, 5'd16, 5'd8, 5'd0}));
		send_probe_set();
		// 8888 into 565 with no alpha field
		load_layout(20'({4'd8, 4'd8, 4'd8, 4'd8}), 20'({5'd16, 5'd8, 5'd0, 5'd24}),
			20'({4'd5, 4'd6, 4'd5, 4'd0}), 20'({5'd11, 5'd5, 5'd0, 5'd16}));
		send_probe_set();
		// oversized width nibbles saturate
		load_layout(20'hFFFFF, 20'({5'd24, 5'd16, 5'd8, 5'd0}),
			20'h0FFFF, 20'({5'd0, 5'd8, 5'd16, 5'd24}));
		send_probe_set();
		// zero colour widths on both sides
		load_layout(20'({4'd0, 4'd3, 4'd0, 4'd8}), 20'({5'd0, 5'd4, 5'd8, 5'd12}),
			20'({4'd8, 4'd0, 4'd4, 4'd2}), 20'({5'd0, 5'd8, 5'd16, 5'd24}));
		send_probe_set();
		// fields reaching past bit 31
		load_layout(20'({4'd8, 4'd8, 4'd8, 4'd8}), 20'({5'd31, 5'd30, 5'd29, 5'd28}),
			20'({4'd8, 4'd8, 4'd8, 4'd8}), 20'({5'd31, 5'd27, 5'd26, 5'd25}));
		send_probe_set();
	endtask

	task automatic test_random_layouts();
		int  sent;
		int  phase;
		int  burst;
		bit  steady;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_PIXELS) begin
			if (phase == 0)
				load_layout('0, '0, '0, '0);
			else if (phase == 1)
				load_layout('1, '1, '1, '1);
			else
				load_layout(rand_widths(), cfg_data_t'($urandom), rand_widths(),
					cfg_data_t'($urandom));
			burst = $urandom_range(16, 64);
			steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < burst; i++) begin
				send_pixel(rand_pixel());
				if (!steady)
					pause_start(pick_gap());
			end
			sent += burst;
			phase++;
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		src_pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SRC_WIDTHS;
		cfg_data = '0;
		fail_count = 0;
		src_widths_q = SRC_WIDTHS_RST;
		src_pos_q = SRC_POSITIONS_RST;
		dst_widths_q = DST_WIDTHS_RST;
		dst_pos_q = DST_POSITIONS_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_layout();
		test_special_layouts();
		test_random_layouts();

		drain();
		repeat (PIPE_LATENCY + 4) @(posedge clk);
		if (fail_count == 0)
			$display("pixel_format_converter test passed");
		else
			$display("pixel_format_converter test failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/pfc_pkg.sv
hdl/pixel_format_converter.sv
tb/sv/tb_top.sv
